// File: rtl/tun_pkg.sv
`timescale 1ns / 1ps

package tun_pkg;

    // Coordinate width and the widths that follow from it.
    localparam int COORD_BITS = 16;
    localparam int FIELD_W    = 16;
    localparam int EDGE_W     = COORD_BITS + 1;
    localparam int PROD_W     = 2 * EDGE_W;
    localparam int CROSS_W    = PROD_W + 1;
    localparam int MSB_W      = $clog2(CROSS_W);

    // Normalized magnitude: top bit of the largest component lands on bit 29.
    localparam int MSB_TARGET = 29;
    localparam int T_W        = MSB_TARGET + 1;
    localparam int SQ_W       = 2 * T_W;
    localparam int SUM_W      = SQ_W + 2;
    localparam int ROOT_W     = SUM_W / 2;
    localparam int SQ_REM_W   = ROOT_W + 2;

    // Q1.14 output and the restoring divider.
    localparam int FRAC_BITS  = 14;
    localparam int QUO_W      = FRAC_BITS + 1;
    localparam int NUM_W      = T_W + FRAC_BITS + 1;
    localparam int DIV_REM_W  = ROOT_W + 1;
    localparam int OUT_W      = 16;
    localparam logic [QUO_W-1:0] FRAC_ONE = QUO_W'(1 << FRAC_BITS);

    localparam int IN_DATA_W  = 9 * FIELD_W;
    localparam int OUT_DATA_W = 3 * OUT_W;

    // Per-item flags that ride along with the arithmetic.
    typedef struct packed {
        logic [2:0] neg;
        logic       degen;
    } tun_flags_t;

    // Flags plus the three normalized magnitudes.
    typedef struct packed {
        tun_flags_t             flags;
        logic [2:0][T_W-1:0]    t;
    } tun_side_t;

endpackage

// File: rtl/tun_cross.sv
`timescale 1ns / 1ps

module tun_cross
    import tun_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [IN_DATA_W-1:0]          in_data,
    output logic                          out_valid,
    output logic [2:0][CROSS_W-1:0]       out_c
);

    logic signed [COORD_BITS-1:0] p [9];
    logic signed [EDGE_W-1:0]     a_next [3];
    logic signed [EDGE_W-1:0]     b_next [3];
    logic signed [EDGE_W-1:0]     a_reg [3];
    logic signed [EDGE_W-1:0]     b_reg [3];
    logic signed [PROD_W-1:0]     prod_reg [6];
    logic [2:0][CROSS_W-1:0]      c_reg;
    logic [2:0]                   vld_reg;

    // Keep the low COORD_BITS bits of a field as a signed coordinate.
    function automatic logic [COORD_BITS-1:0] sext_coord(input logic [FIELD_W-1:0] raw);
        logic [FIELD_W+COORD_BITS-1:0] z;
        z = {{COORD_BITS{1'b0}}, raw};
        return z[COORD_BITS-1:0];
    endfunction

    // Unpack the vertices and form the edges from v1 to v2 and from v1 to v3.
    always_comb
    begin
        for (int i = 0; i < 9; i++)
        begin
            p[i] = $signed(sext_coord(in_data[i*FIELD_W +: FIELD_W]));
        end
        for (int i = 0; i < 3; i++)
        begin
            a_next[i] = EDGE_W'(p[3+i]) - EDGE_W'(p[i]);
            b_next[i] = EDGE_W'(p[6+i]) - EDGE_W'(p[i]);
        end
    end

    // Control: one valid bit per stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[1:0], in_valid};
        end
    end

    // Edges, then the six products, then the cross product.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                a_reg[i] <= a_next[i];
                b_reg[i] <= b_next[i];
            end
            prod_reg[0] <= a_reg[1] * b_reg[2];
            prod_reg[1] <= a_reg[2] * b_reg[1];
            prod_reg[2] <= a_reg[2] * b_reg[0];
            prod_reg[3] <= a_reg[0] * b_reg[2];
            prod_reg[4] <= a_reg[0] * b_reg[1];
            prod_reg[5] <= a_reg[1] * b_reg[0];
            for (int i = 0; i < 3; i++)
            begin
                c_reg[i] <= CROSS_W'(prod_reg[2*i]) - CROSS_W'(prod_reg[2*i+1]);
            end
        end
    end

    assign out_valid = vld_reg[2];
    assign out_c     = c_reg;

endmodule

// File: rtl/tun_scale.sv
`timescale 1ns / 1ps

module tun_scale
    import tun_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    in_valid,
    input  logic [2:0][CROSS_W-1:0] in_c,
    output logic                    out_valid,
    output logic [SUM_W-1:0]        out_sum,
    output tun_side_t               out_side
);

    logic [2:0][CROSS_W-1:0]  mag_next;
    logic [2:0][CROSS_W-1:0]  mag_reg;
    logic [CROSS_W-1:0]       max_next;
    logic [CROSS_W-1:0]       max_reg;
    tun_flags_t               flags_next;
    tun_flags_t               flags_reg;
    logic [MSB_W-1:0]         msb;
    logic [CROSS_W+T_W-2:0]   wide;
    tun_side_t                t_next;
    tun_side_t                t_reg;
    logic [2:0][SQ_W-1:0]     sq_reg;
    tun_side_t                sq_side_reg;
    logic [SUM_W-1:0]         sum_reg;
    tun_side_t                sum_side_reg;
    logic [3:0]               vld_reg;

    // Magnitudes, signs, largest magnitude and the zero test.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            flags_next.neg[i] = in_c[i][CROSS_W-1];
            mag_next[i] = in_c[i][CROSS_W-1] ? CROSS_W'(-in_c[i]) : in_c[i];
        end
        flags_next.degen = (in_c[0] == '0) && (in_c[1] == '0) && (in_c[2] == '0);
        max_next = (mag_next[0] > mag_next[1]) ? mag_next[0] : mag_next[1];
        max_next = (mag_next[2] > max_next) ? mag_next[2] : max_next;
    end

    // Find the top bit of the largest magnitude and scale all three alike.
    always_comb
    begin
        msb = '0;
        for (int i = 0; i < CROSS_W; i++)
        begin
            if (max_reg[i])
            begin
                msb = MSB_W'(i);
            end
        end
        t_next.flags = flags_reg;
        for (int i = 0; i < 3; i++)
        begin
            wide = {mag_reg[i], {(T_W-1){1'b0}}} >> msb;
            t_next.t[i] = wide[T_W-1:0];
        end
    end

    // Control: one valid bit per stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[2:0], in_valid};
        end
    end

    // Magnitude, scaling, squares and their sum.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_reg   <= mag_next;
            max_reg   <= max_next;
            flags_reg <= flags_next;
            t_reg     <= t_next;
            for (int i = 0; i < 3; i++)
            begin
                sq_reg[i] <= t_reg.t[i] * t_reg.t[i];
            end
            sq_side_reg  <= t_reg;
            sum_reg      <= SUM_W'(sq_reg[0]) + SUM_W'(sq_reg[1]) + SUM_W'(sq_reg[2]);
            sum_side_reg <= sq_side_reg;
        end
    end

    assign out_valid = vld_reg[3];
    assign out_sum   = sum_reg;
    assign out_side  = sum_side_reg;

endmodule

// File: rtl/tun_sqrt.sv
`timescale 1ns / 1ps

module tun_sqrt
    import tun_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [SUM_W-1:0]  in_sum,
    input  tun_side_t         in_side,
    output logic              out_valid,
    output logic [ROOT_W-1:0] out_root,
    output tun_side_t         out_side
);

    // One root bit per stage, two radicand bits consumed per stage.
    logic [SQ_REM_W-1:0] rem_in   [ROOT_W];
    logic [ROOT_W-1:0]   root_in  [ROOT_W];
    logic [SUM_W-1:0]    sum_in   [ROOT_W];
    tun_side_t           side_in  [ROOT_W];
    logic [SQ_REM_W-1:0] rem_next [ROOT_W];
    logic [ROOT_W-1:0]   root_next[ROOT_W];
    logic [SQ_REM_W-1:0] rem_reg  [ROOT_W];
    logic [ROOT_W-1:0]   root_reg [ROOT_W];
    logic [SUM_W-1:0]    sum_reg  [ROOT_W];
    tun_side_t           side_reg [ROOT_W];
    logic [ROOT_W-1:0]   vld_reg;
    logic [SQ_REM_W-1:0] r;
    logic [SQ_REM_W-1:0] trial;

    // Restoring square root step for every stage.
    always_comb
    begin
        for (int k = 0; k < ROOT_W; k++)
        begin
            if (k == 0)
            begin
                rem_in[k]  = '0;
                root_in[k] = '0;
                sum_in[k]  = in_sum;
                side_in[k] = in_side;
            end
            else
            begin
                rem_in[k]  = rem_reg[k-1];
                root_in[k] = root_reg[k-1];
                sum_in[k]  = sum_reg[k-1];
                side_in[k] = side_reg[k-1];
            end
            r     = {rem_in[k][SQ_REM_W-3:0], sum_in[k][SUM_W-1-2*k -: 2]};
            trial = {root_in[k], 2'b01};
            if (r >= trial)
            begin
                rem_next[k]  = r - trial;
                root_next[k] = {root_in[k][ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[k]  = r;
                root_next[k] = {root_in[k][ROOT_W-2:0], 1'b0};
            end
        end
    end

    // Control: one valid bit per stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[ROOT_W-2:0], in_valid};
        end
    end

    // Stage registers.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < ROOT_W; k++)
            begin
                rem_reg[k]  <= rem_next[k];
                root_reg[k] <= root_next[k];
                sum_reg[k]  <= sum_in[k];
                side_reg[k] <= side_in[k];
            end
        end
    end

    assign out_valid = vld_reg[ROOT_W-1];
    assign out_root  = root_reg[ROOT_W-1];
    assign out_side  = side_reg[ROOT_W-1];

endmodule

// File: rtl/tun_div.sv
`timescale 1ns / 1ps

module tun_div
    import tun_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic [ROOT_W-1:0]     in_root,
    input  tun_side_t             in_side,
    output logic                  out_valid,
    output logic [2:0][QUO_W-1:0] out_quo,
    output tun_flags_t            out_flags
);

    // Three restoring dividers in lockstep, one quotient bit per stage.
    logic [2:0][NUM_W-1:0]     num_start;
    logic [2:0][NUM_W-1:0]     num_in   [QUO_W];
    logic [2:0][DIV_REM_W-1:0] rem_in   [QUO_W];
    logic [2:0][QUO_W-1:0]     quo_in   [QUO_W];
    logic [ROOT_W-1:0]         den_in   [QUO_W];
    tun_flags_t                flags_in [QUO_W];
    logic [2:0][DIV_REM_W-1:0] rem_next [QUO_W];
    logic [2:0][QUO_W-1:0]     quo_next [QUO_W];
    logic [2:0][NUM_W-1:0]     num_reg  [QUO_W];
    logic [2:0][DIV_REM_W-1:0] rem_reg  [QUO_W];
    logic [2:0][QUO_W-1:0]     quo_reg  [QUO_W];
    logic [ROOT_W-1:0]         den_reg  [QUO_W];
    tun_flags_t                flags_reg[QUO_W];
    logic [QUO_W-1:0]          vld_reg;
    logic [DIV_REM_W-1:0]      r;
    logic                      ge;

    // Rounded numerator: t scaled to Q1.14 plus half the root.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            num_start[i] = {1'b0, in_side.t[i], {FRAC_BITS{1'b0}}}
                         + NUM_W'(in_root >> 1);
        end
    end

    // Division step for every stage and lane.
    always_comb
    begin
        for (int j = 0; j < QUO_W; j++)
        begin
            if (j == 0)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    num_in[j][i] = num_start[i];
                    rem_in[j][i] = DIV_REM_W'(num_start[i][NUM_W-1:QUO_W]);
                    quo_in[j][i] = '0;
                end
                den_in[j]   = in_root;
                flags_in[j] = in_side.flags;
            end
            else
            begin
                num_in[j]   = num_reg[j-1];
                rem_in[j]   = rem_reg[j-1];
                quo_in[j]   = quo_reg[j-1];
                den_in[j]   = den_reg[j-1];
                flags_in[j] = flags_reg[j-1];
            end
            for (int i = 0; i < 3; i++)
            begin
                r  = {rem_in[j][i][DIV_REM_W-2:0], num_in[j][i][QUO_W-1-j]};
                ge = (r >= {1'b0, den_in[j]});
                rem_next[j][i] = ge ? (r - {1'b0, den_in[j]}) : r;
                quo_next[j][i] = {quo_in[j][i][QUO_W-2:0], ge};
            end
        end
    end

    // Control: one valid bit per stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[QUO_W-2:0], in_valid};
        end
    end

    // Stage registers.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < QUO_W; j++)
            begin
                num_reg[j]   <= num_in[j];
                rem_reg[j]   <= rem_next[j];
                quo_reg[j]   <= quo_next[j];
                den_reg[j]   <= den_in[j];
                flags_reg[j] <= flags_in[j];
            end
        end
    end

    assign out_valid = vld_reg[QUO_W-1];
    assign out_quo   = quo_reg[QUO_W-1];
    assign out_flags = flags_reg[QUO_W-1];

endmodule

// File: rtl/triangle_unit_normal.sv
`timescale 1ns / 1ps
// Throughput: one triangle per cycle; the whole pipeline advances together and
// holds while a finished beat waits on m_tready.
// Depth: 3 cross product stages, 4 scaling stages, 31 square root stages,
// 15 divider stages and the output register. Reset clears the valid bits only.

module triangle_unit_normal
    import tun_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // v1_x, v1_y, v1_z, v2_x, v2_y, v2_z, v3_x, v3_y, v3_z from bit 0 up
    input  logic [IN_DATA_W-1:0]  s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // normal_x, normal_y, normal_z from bit 0 up
    output logic [OUT_DATA_W-1:0] m_tdata,
    // degenerate
    output logic                  m_tuser
);

    logic                    en;
    logic                    cross_valid;
    logic [2:0][CROSS_W-1:0] cross_c;
    logic                    scale_valid;
    logic [SUM_W-1:0]        scale_sum;
    tun_side_t               scale_side;
    logic                    sqrt_valid;
    logic [ROOT_W-1:0]       sqrt_root;
    tun_side_t               sqrt_side;
    logic                    div_valid;
    logic [2:0][QUO_W-1:0]   div_quo;
    tun_flags_t              div_flags;
    logic [OUT_DATA_W-1:0]   data_next;
    logic [QUO_W-1:0]        quo_clamp;
    logic [OUT_W-1:0]        comp;
    logic [OUT_DATA_W-1:0]   data_reg;
    logic                    degen_reg;
    logic                    valid_reg;

    // The pipeline moves whenever the output register is free or being taken.
    assign en       = !valid_reg || m_tready;
    assign s_tready = en;

    tun_cross u_cross (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_tvalid),
        .in_data   (s_tdata),
        .out_valid (cross_valid),
        .out_c     (cross_c)
    );

    tun_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (cross_valid),
        .in_c      (cross_c),
        .out_valid (scale_valid),
        .out_sum   (scale_sum),
        .out_side  (scale_side)
    );

    tun_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (scale_valid),
        .in_sum    (scale_sum),
        .in_side   (scale_side),
        .out_valid (sqrt_valid),
        .out_root  (sqrt_root),
        .out_side  (sqrt_side)
    );

    tun_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sqrt_valid),
        .in_root   (sqrt_root),
        .in_side   (sqrt_side),
        .out_valid (div_valid),
        .out_quo   (div_quo),
        .out_flags (div_flags)
    );

    // Clamp to one, apply the sign, and zero a degenerate triangle.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            quo_clamp = (div_quo[i] > FRAC_ONE) ? FRAC_ONE : div_quo[i];
            comp = div_flags.neg[i] ? OUT_W'(-OUT_W'(quo_clamp)) : OUT_W'(quo_clamp);
            data_next[i*OUT_W +: OUT_W] = div_flags.degen ? '0 : comp;
        end
    end

    // Output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= div_valid;
        end
    end

    // Output payload.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg  <= data_next;
            degen_reg <= div_flags.degen;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = degen_reg;

endmodule
